// ----- src/mau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_pkg
// Shared widths, operation and error codes, and the conditional-subtract
// helper used by the serial reduce and multiply stages of the arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int MOD_W     = 31;
  localparam int OP_W      = 64;
  localparam int EXP_BITS  = 63;
  localparam int RED_STEPS = OP_W;
  localparam int CNT_W     = $clog2(RED_STEPS);
  localparam int PASS_LAST = MOD_W - 1;
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(998244353);

  typedef enum logic [2:0] {
    KIND_REDUCE = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_SUB    = 3'd2,
    KIND_MUL    = 3'd3,
    KIND_DIV    = 3'd4,
    KIND_POW    = 3'd5,
    KIND_INV    = 3'd6,
    KIND_NEG    = 3'd7
  } kind_t;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_NOINV  = 2'd1;
  localparam logic [1:0] ERR_NEGEXP = 2'd2;

  // v is known to be below 2*m: one compare and subtract brings it in range
  function automatic logic [MOD_W-1:0] mod_sub_if(input logic [MOD_W:0] v,
                                                  input logic [MOD_W-1:0] m);
    logic [MOD_W:0] t;
    t = v - {1'b0, m};
    return (v >= {1'b0, m}) ? t[MOD_W-1:0] : v[MOD_W-1:0];
  endfunction

endpackage

// ----- src/mau_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_reduce
// Bit-serial reduction of a signed 64-bit operand into 0..m-1, one
// magnitude bit per cycle while step is high, MSB first.
// ----------------------------------------------------------------------------
module mau_reduce import mau_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [OP_W-1:0]  raw,
  input  logic [MOD_W-1:0] m,
  output logic [MOD_W-1:0] res
);

  logic [OP_W-1:0]  mag;
  logic             neg;
  logic [MOD_W-1:0] r;

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= raw[OP_W-1];
      mag <= raw[OP_W-1] ? (~raw + OP_W'(1)) : raw;
      r   <= '0;
    end else if (step) begin
      r   <= mod_sub_if({r, mag[OP_W-1]}, m);
      mag <= {mag[OP_W-2:0], 1'b0};
    end
  end

  // negative operand: m - r, with r == 0 folding back to zero
  assign res = neg ? mod_sub_if({1'b0, m} - {1'b0, r}, m) : r;

endmodule

// ----- src/mau_mulser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_mulser
// Serial modular multiply-accumulate: acc = 2*acc + bit*x (mod m) per
// step, multiplier bits fed MSB first.
// ----------------------------------------------------------------------------
module mau_mulser import mau_pkg::*; (
  input  logic             clk,
  input  logic             clr,
  input  logic             step,
  input  logic             mbit,
  input  logic [MOD_W-1:0] x,
  input  logic [MOD_W-1:0] m,
  output logic [MOD_W-1:0] acc
);

  logic [MOD_W-1:0] dbl;
  logic [MOD_W-1:0] acc_next;

  always_comb begin
    dbl      = mod_sub_if({acc, 1'b0}, m);
    acc_next = mod_sub_if({1'b0, dbl} + (mbit ? {1'b0, x} : '0), m);
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (step) begin
      acc <= acc_next;
    end
  end

endmodule

// ----- src/modular_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular reduce/add/sub/mul/div/pow/inverse/negate over a 31-bit modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries kind, operand_a, operand_b.
//   Output channel (out_valid/out_ready) carries value and error.
//   cfg_we/cfg_data write the modulus; do so only while the unit is idle.
// Sequence, one word at a time:
//   Both operands are reduced in parallel, one bit per cycle.
//   reduce/add/sub/negate then finish directly; mul adds a serial multiply.
//   pow runs one square-and-multiply round per exponent bit up
//   to the highest set bit (at most 63 rounds).
//   inverse runs one round per Euclid step (shift-subtract
//   division merged with the coefficient update); div adds one multiply.
//   mul, pow, div and inverse all run on the serial multiplier lanes.
// Reset clears the handshake state and sets the modulus to 998244353.
// A finished word waits in the output register while out_ready is low;
// the next word is accepted meanwhile and holds in its last state until
// the output register frees up.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit import mau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [MOD_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       kind,
  input  logic [OP_W-1:0]  operand_a,
  input  logic [OP_W-1:0]  operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [MOD_W-1:0] value,
  output logic [1:0]       error
);

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_DISP, S_MUL, S_MULEND, S_POW, S_PSQ, S_PUPD,
    S_EUC, S_DIV, S_EUPD, S_FIN
  } state_t;

  state_t state;

  logic [MOD_W-1:0]    modulus;
  logic [MOD_W-1:0]    m;
  kind_t               op;
  logic [OP_W-1:0]     raw_b;
  logic [CNT_W-1:0]    cnt;
  logic [MOD_W-1:0]    mbits;
  logic [MOD_W-1:0]    mulx;
  logic [MOD_W-1:0]    acc, sq;
  logic [EXP_BITS-1:0] ex;
  logic [MOD_W-1:0]    ra, rb, rem, u, v;
  logic [MOD_W-1:0]    res_val;
  logic [1:0]          res_err;

  logic [MOD_W-1:0] ares, bres, lane0, lane1, one;
  logic             red_load, red_step;
  logic             mul_clr, step0, step1, bit0;
  logic [MOD_W-1:0] x0;
  logic [MOD_W:0]   rem_sh;
  logic             qbit;
  logic [MOD_W-1:0] rem_next;

  assign in_ready = (state == S_IDLE);
  assign one      = mod_sub_if((MOD_W+1)'(1), m);
  assign red_load = in_valid && in_ready;
  assign red_step = (state == S_RED);

  // lane control
  assign mul_clr = (state == S_DISP) || (state == S_POW) || (state == S_EUC);
  assign step0   = (state == S_MUL) || (state == S_PSQ) || (state == S_DIV);
  assign step1   = (state == S_PSQ);
  assign bit0    = (state == S_DIV) ? qbit : mbits[MOD_W-1];
  assign x0      = (state == S_PSQ) ? acc : ((state == S_DIV) ? v : mulx);

  // restoring division step of ra by rb, dividend bits streamed from mbits
  always_comb begin
    rem_sh   = {rem, mbits[MOD_W-1]};
    qbit     = (rem_sh >= {1'b0, rb});
    rem_next = qbit ? MOD_W'(rem_sh - {1'b0, rb}) : rem_sh[MOD_W-1:0];
  end

  mau_reduce u_red_a (
    .clk(clk), .load(red_load), .step(red_step), .raw(operand_a), .m(m), .res(ares)
  );
  mau_reduce u_red_b (
    .clk(clk), .load(red_load), .step(red_step), .raw(operand_b), .m(m), .res(bres)
  );
  mau_mulser u_mul0 (
    .clk(clk), .clr(mul_clr), .step(step0), .mbit(bit0), .x(x0), .m(m), .acc(lane0)
  );
  mau_mulser u_mul1 (
    .clk(clk), .clr(mul_clr), .step(step1), .mbit(mbits[MOD_W-1]), .x(sq), .m(m),
    .acc(lane1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= kind_t'(kind);
            raw_b <= operand_b;
            m     <= (modulus == '0) ? MOD_W'(1) : modulus;
            cnt   <= '0;
            state <= S_RED;
          end
        end
        S_RED: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(RED_STEPS - 1)) begin
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_err <= ERR_OK;
          cnt     <= '0;
          unique case (op)
            KIND_REDUCE: begin
              res_val <= ares;
              state   <= S_FIN;
            end
            KIND_ADD: begin
              res_val <= mod_sub_if({1'b0, ares} + {1'b0, bres}, m);
              state   <= S_FIN;
            end
            KIND_SUB: begin
              res_val <= mod_sub_if({1'b0, ares} + {1'b0, m} - {1'b0, bres}, m);
              state   <= S_FIN;
            end
            KIND_NEG: begin
              res_val <= mod_sub_if({1'b0, m} - {1'b0, ares}, m);
              state   <= S_FIN;
            end
            KIND_MUL: begin
              mulx  <= ares;
              mbits <= bres;
              state <= S_MUL;
            end
            KIND_POW: begin
              if (raw_b[OP_W-1]) begin
                res_val <= '0;
                res_err <= ERR_NEGEXP;
                state   <= S_FIN;
              end else begin
                acc   <= one;
                sq    <= ares;
                ex    <= raw_b[EXP_BITS-1:0];
                state <= S_POW;
              end
            end
            KIND_DIV, KIND_INV: begin
              ra    <= (op == KIND_INV) ? ares : bres;
              rb    <= m;
              u     <= one;
              v     <= '0;
              mulx  <= ares;
              state <= S_EUC;
            end
            default: state <= S_FIN;
          endcase
        end
        S_MUL: begin
          mbits <= {mbits[MOD_W-2:0], 1'b0};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(PASS_LAST)) begin
            state <= S_MULEND;
          end
        end
        S_MULEND: begin
          res_val <= lane0;
          state   <= S_FIN;
        end
        S_POW: begin
          cnt   <= '0;
          mbits <= sq;
          if (ex == '0) begin
            res_val <= acc;
            state   <= S_FIN;
          end else begin
            state <= S_PSQ;
          end
        end
        S_PSQ: begin
          mbits <= {mbits[MOD_W-2:0], 1'b0};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(PASS_LAST)) begin
            state <= S_PUPD;
          end
        end
        S_PUPD: begin
          if (ex[0]) begin
            acc <= lane0;
          end
          sq    <= lane1;
          ex    <= ex >> 1;
          state <= S_POW;
        end
        S_EUC: begin
          cnt <= '0;
          rem <= '0;
          if (rb == '0) begin
            res_err <= (ra == MOD_W'(1)) ? ERR_OK : ERR_NOINV;
            if (op == KIND_INV) begin
              res_val <= u;
              state   <= S_FIN;
            end else begin
              mbits <= u;
              state <= S_MUL;
            end
          end else begin
            mbits <= ra;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem   <= rem_next;
          mbits <= {mbits[MOD_W-2:0], 1'b0};
          cnt   <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(PASS_LAST)) begin
            state <= S_EUPD;
          end
        end
        S_EUPD: begin
          // lane0 now holds q*v mod m
          ra    <= rb;
          rb    <= rem;
          u     <= v;
          v     <= mod_sub_if({1'b0, u} + {1'b0, m} - {1'b0, lane0}, m);
          state <= S_EUC;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            value <= res_val;
            error <= res_err;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_checker
// Port-level checks for the modular arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
module mau_checker import mau_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [MOD_W-1:0] value,
  input logic [1:0]       error
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(error))
    else $error("output word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error != 2'd3)
    else $error("undefined error code");

  a_negexp: assert property (@(posedge clk) disable iff (rst)
    out_valid && error == ERR_NEGEXP |-> value == '0)
    else $error("negative exponent with nonzero value");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .value(value), .error(error)
);

// ----- tb/modular_arithmetic_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_test
// Drives signed operand pairs of every operation through the unit under a
// series of moduli, predicts each residue and error code, and compares the
// results in order with random input gaps and output stalls.
// ----------------------------------------------------------------------------

class residue_board;
  logic [30:0] exp_value[$];
  logic [1:0]  exp_error[$];
  int          fails;
  int          checked;

  function void note_word(logic [30:0] v, logic [1:0] e);
    exp_value.push_back(v);
    exp_error.push_back(e);
  endfunction

  function void check_word(logic [30:0] v, logic [1:0] e);
    logic [30:0] ev;
    logic [1:0]  ee;
    if (exp_value.size() == 0) begin
      $display("%0t: unexpected word value=%0d error=%0d", $time, v, e);
      fails++;
      return;
    end
    ev = exp_value.pop_front();
    ee = exp_error.pop_front();
    checked++;
    if (v !== ev) begin
      $display("%0t: value mismatch expected %0d actual %0d", $time, ev, v);
      fails++;
    end
    if (e !== ee) begin
      $display("%0t: error mismatch expected %0d actual %0d", $time, ee, e);
      fails++;
    end
  endfunction

  function int pending();
    return exp_value.size();
  endfunction
endclass

module modular_arithmetic_unit_test;
  import mau_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [MOD_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [2:0]       kind;
  logic [OP_W-1:0]  operand_a;
  logic [OP_W-1:0]  operand_b;
  logic             out_valid;
  logic             out_ready;
  logic [MOD_W-1:0] value;
  logic [1:0]       error;

  residue_board board;
  logic [63:0]  cur_mod;
  int           idle_cycles;
  int           words_in;

  localparam int IDLE_LIMIT = 40000;

  modular_arithmetic_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .error(error)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] to_residue(logic [63:0] raw, logic [63:0] m);
    logic [63:0] r;
    if (raw[63]) begin
      r = (-raw) % m;
      return (r == 0) ? 64'd0 : m - r;
    end
    return raw % m;
  endfunction

  // extended Euclid; ok reports gcd == 1
  function automatic logic [63:0] euclid_inv(logic [63:0] x, logic [63:0] m,
                                             output bit ok);
    longint ra, rb, u, v, q, t;
    ra = x; rb = m; u = 1; v = 0;
    while (rb != 0) begin
      q = ra / rb;
      t = ra - q * rb; ra = rb; rb = t;
      t = u - q * v; u = v; v = t;
    end
    ok = (ra == 1);
    u = u % longint'(m);
    if (u < 0) u += longint'(m);
    return u;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex,
                                          logic [63:0] m);
    logic [63:0] acc, sq;
    acc = 1 % m;
    sq = base;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (ex[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc;
  endfunction

  function automatic void predict_word(kind_t k, logic [63:0] ra, logic [63:0] rb);
    logic [63:0] m, a, b, v;
    logic [1:0]  e;
    bit          ok;
    m = (cur_mod == 0) ? 64'd1 : cur_mod;
    a = to_residue(ra, m);
    b = to_residue(rb, m);
    e = ERR_OK;
    ok = 1;
    case (k)
      KIND_REDUCE: v = a;
      KIND_ADD:    v = (a + b) % m;
      KIND_SUB:    v = (a + m - b) % m;
      KIND_MUL:    v = (a * b) % m;
      KIND_DIV: begin
        v = (a * euclid_inv(b, m, ok)) % m;
        if (!ok) e = ERR_NOINV;
      end
      KIND_POW: begin
        if (rb[63]) begin
          v = 0;
          e = ERR_NEGEXP;
        end else begin
          v = pow_mod(a, rb, m);
        end
      end
      KIND_INV: begin
        v = euclid_inv(a, m, ok);
        if (!ok) e = ERR_NOINV;
      end
      default: v = (m - a) % m;
    endcase
    board.note_word(v[30:0], e);
  endfunction

  // output stall pattern and checking
  int stall_mode;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.check_word(value, error);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d words pending", board.pending());
        $display("** modular_arithmetic_unit: FAILED **");
        $finish;
      end
    end
  end

  // valid stays high after an accept; callers drop it before any idle cycle
  task automatic send_word(kind_t k, logic [63:0] a, logic [63:0] b);
    in_valid <= 1'b1;
    kind <= k;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(k, a, b);
    words_in++;
  endtask

  task automatic gap();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_modulus(logic [30:0] m);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mod = m;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_operand(logic [63:0] m);
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return $urandom_range(0, 100);
      2: return -longint'($urandom_range(0, 100));
      3: return m * $urandom_range(0, 3);
      4: return -(m * $urandom_range(1, 3));
      default: return {32'd0, $urandom} % (m == 0 ? 64'd1 : m);
    endcase
  endfunction

  function automatic logic [63:0] rand_exponent();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return {1'b0, 31'($urandom), $urandom};
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // random words under the current modulus, which the caller sets; exponents mostly small to keep pow short
  task automatic random_phase(int count);
    kind_t       k;
    logic [63:0] m, a, b;
    int          burst;
    int          n;
    m = (cur_mod == 0) ? 64'd1 : cur_mod;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        k = kind_t'($urandom_range(0, 7));
        a = rand_operand(m);
        b = (k == KIND_POW) ? rand_exponent() : rand_operand(m);
        send_word(k, a, b);
        burst--;
        count--;
      end
      n = $urandom_range(0, 15);
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  logic [30:0] mods[8];

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = '0;
    operand_a = '0;
    operand_b = '0;
    stall_mode = 0;
    words_in = 0;
    idle_cycles = 0;
    cur_mod = MOD_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, under the reset modulus
    send_word(KIND_REDUCE, 64'h8000_0000_0000_0000, 0); gap();
    send_word(KIND_REDUCE, 64'h7FFF_FFFF_FFFF_FFFF, 0); gap();
    send_word(KIND_REDUCE, -64'd998244353 * 3, 0);
    send_word(KIND_ADD, -64'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(KIND_SUB, 0, 64'hFFFF_FFFF_FFFF_FFFF); gap();
    send_word(KIND_MUL, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_word(KIND_DIV, 5, 3);
    send_word(KIND_DIV, 5, 998244353); gap();
    send_word(KIND_POW, 3, 0);
    send_word(KIND_POW, 3, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(KIND_POW, 3, -64'd5);
    send_word(KIND_INV, 0, 0);
    send_word(KIND_INV, -64'd2, 0); gap();
    send_word(KIND_NEG, 0, 0);
    send_word(KIND_NEG, 64'h5555_5555_AAAA_AAAA, 0);

    // composite modulus exercises the non-invertible path
    set_modulus(31'd12);
    send_word(KIND_INV, 4, 0);
    send_word(KIND_DIV, 7, 6);
    send_word(KIND_INV, 5, 0);
    set_modulus(31'd0);
    send_word(KIND_POW, 9, 0);
    send_word(KIND_INV, 3, 0);
    set_modulus(31'd1);
    send_word(KIND_DIV, 3, 2);
    send_word(KIND_NEG, -64'd7, 0);

    mods[0] = 31'h7FFF_FFFF; mods[1] = 31'd1; mods[2] = 31'd2; mods[3] = 31'd0;
    mods[4] = 31'd1000000007; mods[5] = 31'd360; mods[6] = 31'h4000_0000;
    mods[7] = 31'd998244353;
    for (int p = 0; p < 8; p++) begin
      set_modulus(p == 7 ? 31'($urandom) : mods[p]);
      stall_mode = p % 3;
      random_phase(p < 3 ? 60 : 50);
      if (p == 4) drain();  // sender holds until all results are back
    end

    drain();
    $display("%0d words sent, %0d results checked across twelve modulus settings",
             words_in, board.checked);
    $display("all eight operations with signed extremes, bursts and stalls");
    if (board.fails == 0 && board.pending() == 0) begin
      $display("** modular_arithmetic_unit: PASSED **");
    end else begin
      $display("** modular_arithmetic_unit: FAILED **");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/mau_pkg.sv
src/mau_reduce.sv
src/mau_mulser.sv
src/modular_arithmetic_unit.sv
src/mau_checker.sv
tb/modular_arithmetic_unit_test.sv
